// ===== design/stt_pkg.sv =====
`timescale 1ns / 1ps

package stt_pkg;

  localparam int VALUE_W = 32;
  localparam int TEXT_W = 8;
  localparam int LINE_W = 24;
  localparam logic [TEXT_W-1:0] MAX_TEXT = 8'd255;
  localparam logic [LINE_W-1:0] LINE_MAX = 24'hFFFFFF;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = 2;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef enum logic [3:0] {
    PH_IDLE, PH_COMMENT, PH_NUMBER, PH_IDENT, PH_STRING, PH_STR_ESC,
    PH_CHAR1, PH_CHAR2, PH_EQ, PH_BANG, PH_LT, PH_GT, PH_DONE, PH_ERROR
  } phase_t;

  typedef enum logic [4:0] {
    TK_EOF, TK_INT, TK_STR, TK_IDENT, TK_ASSIGN, TK_EQ, TK_NE, TK_LT, TK_GT,
    TK_LE, TK_GE, TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_PERCENT,
    TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_COMMA
  } tok_t;

  typedef enum logic [1:0] {
    IK_TOKEN, IK_TEXT, IK_ERROR
  } ikind_t;

  typedef enum logic [2:0] {
    ER_NEWLINE_IN_STR, ER_UNTERM_STR, ER_BAD_CHAR, ER_STRAY_BANG, ER_UNEXPECTED
  } err_t;

  typedef struct packed {
    ikind_t kind;
    tok_t tok;
    logic [VALUE_W-1:0] value;
    logic [7:0] tbyte;
    logic [TEXT_W-1:0] tlen;
    err_t err;
  } item_t;

  typedef struct packed {
    item_t item;
    logic [LINE_W-1:0] line;
    logic last;
  } entry_t;

  function automatic item_t make_tok(tok_t tk, logic [VALUE_W-1:0] val,
                                     logic [TEXT_W-1:0] len);
    item_t it;
    it.kind = IK_TOKEN;
    it.tok = tk;
    it.value = val;
    it.tbyte = 8'd0;
    it.tlen = len;
    it.err = ER_NEWLINE_IN_STR;
    return it;
  endfunction

  function automatic item_t make_text(logic [7:0] b, logic [TEXT_W-1:0] len);
    item_t it;
    it.kind = IK_TEXT;
    it.tok = TK_EOF;
    it.value = '0;
    it.tbyte = b;
    it.tlen = len;
    it.err = ER_NEWLINE_IN_STR;
    return it;
  endfunction

  function automatic item_t make_err(err_t code);
    item_t it;
    it.kind = IK_ERROR;
    it.tok = TK_EOF;
    it.value = '0;
    it.tbyte = 8'd0;
    it.tlen = '0;
    it.err = code;
    return it;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDERSCORE);
  endfunction

endpackage

// ===== design/stt_if.sv =====
`timescale 1ns / 1ps

interface stt_in_if;
  logic valid;
  logic ready;
  logic [7:0] source_byte;
  logic end_of_source;

  modport source (output valid, output source_byte, output end_of_source,
                  input ready);
  modport sink (input valid, input source_byte, input end_of_source,
                output ready);
endinterface

interface stt_out_if;
  logic valid;
  logic ready;
  logic [1:0] item_kind;
  logic [4:0] token_kind;
  logic [31:0] int_value;
  logic [7:0] text_byte;
  logic [7:0] text_length;
  logic [23:0] line_number;
  logic [2:0] error_code;
  logic last_of_run;

  modport source (output valid, output item_kind, output token_kind,
                  output int_value, output text_byte, output text_length,
                  output line_number, output error_code, output last_of_run,
                  input ready);
  modport sink (input valid, input item_kind, input token_kind,
                input int_value, input text_byte, input text_length,
                input line_number, input error_code, input last_of_run,
                output ready);
endinterface

// ===== design/source_text_tokenizer_core.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Payload
// in_ch    | sink      | source_byte, end_of_source
// out_ch   | source    | item_kind, token_kind, int_value, text_byte,
//          |           | text_length, line_number, error_code, last_of_run
//
// Each accepted request is scanned in the cycle it arrives and its zero, one or two
// results are written into a four-entry result queue; while input ready is high, one
// request per cycle is taken. The output is taken from the head of that queue, one
// result per cycle while output ready is high. Input ready falls when fewer than two
// queue entries are free, so a stalled output holds the input back without loss.
// Reset is synchronous and active low and returns the scanner to line one, between tokens.

module source_text_tokenizer_core (
  input  logic clk,
  input  logic rst_n,
  stt_in_if.sink in_ch,
  stt_out_if.source out_ch
);

  stt_pkg::phase_t ph_r, ph_nxt;
  logic [stt_pkg::VALUE_W-1:0] num_r, num_nxt;
  logic [stt_pkg::TEXT_W-1:0] tc_r, tc_nxt;
  logic [stt_pkg::LINE_W-1:0] line_r, line_nxt;
  logic [7:0] lit_r, lit_nxt;

  stt_pkg::entry_t fifo_r [stt_pkg::FIFO_DEPTH];
  logic [stt_pkg::FIFO_AW-1:0] wp_r, rp_r;
  logic [stt_pkg::FIFO_AW:0] cnt_r;

  logic acc, pop;
  logic [7:0] c;
  logic eof;
  logic [3:0] digit;
  logic pre_v, sub_v, sub_idle, sub_str;
  stt_pkg::item_t pre_item, sub_item;
  logic [stt_pkg::TEXT_W-1:0] tc_a;
  logic push0, push1;
  stt_pkg::entry_t ent0, ent1;
  logic [stt_pkg::FIFO_AW:0] n_push;

  assign acc = in_ch.valid && in_ch.ready;
  assign pop = out_ch.valid && out_ch.ready;
  assign c = in_ch.source_byte;
  assign eof = in_ch.end_of_source || (c == stt_pkg::CH_NUL);
  assign digit = 4'(c - stt_pkg::CH_ZERO);

  always_comb begin
    ph_nxt = ph_r;
    num_nxt = num_r;
    tc_nxt = tc_r;
    line_nxt = line_r;
    lit_nxt = lit_r;
    pre_v = 1'b0;
    pre_item = stt_pkg::make_err(stt_pkg::ER_NEWLINE_IN_STR);
    sub_v = 1'b0;
    sub_item = stt_pkg::make_err(stt_pkg::ER_NEWLINE_IN_STR);
    sub_idle = 1'b0;
    sub_str = 1'b0;
    tc_a = tc_r;

    unique case (ph_r)
      stt_pkg::PH_IDLE: begin
        sub_idle = 1'b1;
      end
      stt_pkg::PH_COMMENT: begin
        sub_idle = eof || (c == stt_pkg::CH_LF);
      end
      stt_pkg::PH_NUMBER: begin
        if (!eof && stt_pkg::is_digit(c)) begin
          num_nxt = {num_r[stt_pkg::VALUE_W-4:0], 3'b000}
                  + {num_r[stt_pkg::VALUE_W-2:0], 1'b0}
                  + stt_pkg::VALUE_W'(digit);
        end else begin
          pre_v = 1'b1;
          pre_item = stt_pkg::make_tok(stt_pkg::TK_INT, num_r, '0);
          sub_idle = 1'b1;
        end
      end
      stt_pkg::PH_IDENT: begin
        if (!eof && (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c))) begin
          if (tc_r < stt_pkg::MAX_TEXT) begin
            tc_nxt = tc_r + 1'b1;
            pre_v = 1'b1;
            pre_item = stt_pkg::make_text(c, tc_r + 1'b1);
          end
        end else begin
          pre_v = 1'b1;
          pre_item = stt_pkg::make_tok(stt_pkg::TK_IDENT, '0, tc_r);
          sub_idle = 1'b1;
        end
      end
      stt_pkg::PH_STRING: begin
        sub_str = 1'b1;
      end
      stt_pkg::PH_STR_ESC: begin
        ph_nxt = stt_pkg::PH_STRING;
        if (!eof && (c == stt_pkg::CH_LOWER_N || c == stt_pkg::CH_DQUOTE ||
                     c == stt_pkg::CH_BSLASH)) begin
          if (tc_r < stt_pkg::MAX_TEXT) begin
            tc_nxt = tc_r + 1'b1;
            pre_v = 1'b1;
            pre_item = stt_pkg::make_text(
              (c == stt_pkg::CH_LOWER_N) ? stt_pkg::CH_LF : c, tc_r + 1'b1);
          end
        end else begin
          if (tc_r < stt_pkg::MAX_TEXT) begin
            tc_a = tc_r + 1'b1;
            tc_nxt = tc_r + 1'b1;
            pre_v = 1'b1;
            pre_item = stt_pkg::make_text(stt_pkg::CH_BSLASH, tc_r + 1'b1);
          end
          sub_str = 1'b1;
        end
      end
      stt_pkg::PH_CHAR1: begin
        if (eof) begin
          pre_v = 1'b1;
          pre_item = stt_pkg::make_err(stt_pkg::ER_BAD_CHAR);
          ph_nxt = stt_pkg::PH_ERROR;
        end else begin
          lit_nxt = c;
          ph_nxt = stt_pkg::PH_CHAR2;
        end
      end
      stt_pkg::PH_CHAR2: begin
        pre_v = 1'b1;
        if (!eof && c == stt_pkg::CH_SQUOTE) begin
          pre_item = stt_pkg::make_tok(stt_pkg::TK_INT,
                                       stt_pkg::VALUE_W'(lit_r), '0);
          ph_nxt = stt_pkg::PH_IDLE;
        end else begin
          pre_item = stt_pkg::make_err(stt_pkg::ER_BAD_CHAR);
          ph_nxt = stt_pkg::PH_ERROR;
        end
      end
      stt_pkg::PH_EQ, stt_pkg::PH_LT, stt_pkg::PH_GT: begin
        pre_v = 1'b1;
        if (!eof && c == stt_pkg::CH_EQ) begin
          pre_item = stt_pkg::make_tok(
            (ph_r == stt_pkg::PH_EQ) ? stt_pkg::TK_EQ :
            (ph_r == stt_pkg::PH_LT) ? stt_pkg::TK_LE : stt_pkg::TK_GE, '0, '0);
          ph_nxt = stt_pkg::PH_IDLE;
        end else begin
          pre_item = stt_pkg::make_tok(
            (ph_r == stt_pkg::PH_EQ) ? stt_pkg::TK_ASSIGN :
            (ph_r == stt_pkg::PH_LT) ? stt_pkg::TK_LT : stt_pkg::TK_GT, '0, '0);
          sub_idle = 1'b1;
        end
      end
      stt_pkg::PH_BANG: begin
        pre_v = 1'b1;
        if (!eof && c == stt_pkg::CH_EQ) begin
          pre_item = stt_pkg::make_tok(stt_pkg::TK_NE, '0, '0);
          ph_nxt = stt_pkg::PH_IDLE;
        end else begin
          pre_item = stt_pkg::make_err(stt_pkg::ER_STRAY_BANG);
          ph_nxt = stt_pkg::PH_ERROR;
        end
      end
      default: begin
      end
    endcase

    if (sub_idle) begin
      ph_nxt = stt_pkg::PH_IDLE;
      if (eof) begin
        sub_v = 1'b1;
        sub_item = stt_pkg::make_tok(stt_pkg::TK_EOF, '0, '0);
        ph_nxt = stt_pkg::PH_DONE;
      end else if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB ||
                   c == stt_pkg::CH_CR) begin
        ph_nxt = stt_pkg::PH_IDLE;
      end else if (c == stt_pkg::CH_LF) begin
        if (line_r < stt_pkg::LINE_MAX) begin
          line_nxt = line_r + 1'b1;
        end
      end else if (c == stt_pkg::CH_TILDE) begin
        ph_nxt = stt_pkg::PH_COMMENT;
      end else if (stt_pkg::is_digit(c)) begin
        num_nxt = stt_pkg::VALUE_W'(digit);
        ph_nxt = stt_pkg::PH_NUMBER;
      end else if (stt_pkg::is_alpha(c)) begin
        tc_nxt = stt_pkg::TEXT_W'(1);
        sub_v = 1'b1;
        sub_item = stt_pkg::make_text(c, stt_pkg::TEXT_W'(1));
        ph_nxt = stt_pkg::PH_IDENT;
      end else begin
        priority case (c)
          stt_pkg::CH_DQUOTE: begin
            tc_nxt = '0;
            ph_nxt = stt_pkg::PH_STRING;
          end
          stt_pkg::CH_SQUOTE: ph_nxt = stt_pkg::PH_CHAR1;
          stt_pkg::CH_EQ: ph_nxt = stt_pkg::PH_EQ;
          stt_pkg::CH_BANG: ph_nxt = stt_pkg::PH_BANG;
          stt_pkg::CH_LT: ph_nxt = stt_pkg::PH_LT;
          stt_pkg::CH_GT: ph_nxt = stt_pkg::PH_GT;
          stt_pkg::CH_PLUS: begin
            sub_v = 1'b1;
            sub_item = stt_pkg::make_tok(stt_pkg::TK_PLUS, '0, '0);
          end
          stt_pkg::CH_MINUS: begin
            sub_v = 1'b1;
            sub_item = stt_pkg::make_tok(stt_pkg::TK_MINUS, '0, '0);
          end
          stt_pkg::CH_STAR: begin
            sub_v = 1'b1;
            sub_item = stt_pkg::make_tok(stt_pkg::TK_STAR, '0, '0);
          end
          stt_pkg::CH_SLASH: begin
            sub_v = 1'b1;
            sub_item = stt_pkg::make_tok(stt_pkg::TK_SLASH, '0, '0);
          end
          stt_pkg::CH_PERCENT: begin
            sub_v = 1'b1;
            sub_item = stt_pkg::make_tok(stt_pkg::TK_PERCENT, '0, '0);
          end
          stt_pkg::CH_LPAREN: begin
            sub_v = 1'b1;
            sub_item = stt_pkg::make_tok(stt_pkg::TK_LPAREN, '0, '0);
          end
          stt_pkg::CH_RPAREN: begin
            sub_v = 1'b1;
            sub_item = stt_pkg::make_tok(stt_pkg::TK_RPAREN, '0, '0);
          end
          stt_pkg::CH_LBRACE: begin
            sub_v = 1'b1;
            sub_item = stt_pkg::make_tok(stt_pkg::TK_LBRACE, '0, '0);
          end
          stt_pkg::CH_RBRACE: begin
            sub_v = 1'b1;
            sub_item = stt_pkg::make_tok(stt_pkg::TK_RBRACE, '0, '0);
          end
          stt_pkg::CH_COMMA: begin
            sub_v = 1'b1;
            sub_item = stt_pkg::make_tok(stt_pkg::TK_COMMA, '0, '0);
          end
          default: begin
            sub_v = 1'b1;
            sub_item = stt_pkg::make_err(stt_pkg::ER_UNEXPECTED);
            ph_nxt = stt_pkg::PH_ERROR;
          end
        endcase
      end
    end

    if (sub_str) begin
      ph_nxt = stt_pkg::PH_STRING;
      if (eof) begin
        sub_v = 1'b1;
        sub_item = stt_pkg::make_err(stt_pkg::ER_UNTERM_STR);
        ph_nxt = stt_pkg::PH_ERROR;
      end else if (c == stt_pkg::CH_DQUOTE) begin
        sub_v = 1'b1;
        sub_item = stt_pkg::make_tok(stt_pkg::TK_STR, '0, tc_a);
        ph_nxt = stt_pkg::PH_IDLE;
      end else if (c == stt_pkg::CH_LF) begin
        sub_v = 1'b1;
        sub_item = stt_pkg::make_err(stt_pkg::ER_NEWLINE_IN_STR);
        ph_nxt = stt_pkg::PH_ERROR;
      end else if (c == stt_pkg::CH_BSLASH) begin
        ph_nxt = stt_pkg::PH_STR_ESC;
      end else if (tc_a < stt_pkg::MAX_TEXT) begin
        tc_nxt = tc_a + 1'b1;
        sub_v = 1'b1;
        sub_item = stt_pkg::make_text(c, tc_a + 1'b1);
      end
    end
  end

  // Every result of one request carries the line count from before that request.
  always_comb begin
    push0 = acc && (pre_v || sub_v);
    push1 = acc && pre_v && sub_v;
    ent0.item = pre_v ? pre_item : sub_item;
    ent0.line = line_r;
    ent0.last = !(pre_v && sub_v);
    ent1.item = sub_item;
    ent1.line = line_r;
    ent1.last = 1'b1;
    n_push = (stt_pkg::FIFO_AW + 1)'(push0) + (stt_pkg::FIFO_AW + 1)'(push1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= stt_pkg::PH_IDLE;
      num_r <= '0;
      tc_r <= '0;
      line_r <= stt_pkg::LINE_W'(1);
      lit_r <= '0;
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (acc) begin
        ph_r <= ph_nxt;
        num_r <= num_nxt;
        tc_r <= tc_nxt;
        line_r <= line_nxt;
        lit_r <= lit_nxt;
      end
      wp_r <= wp_r + n_push[stt_pkg::FIFO_AW-1:0];
      rp_r <= rp_r + stt_pkg::FIFO_AW'(pop);
      cnt_r <= cnt_r + n_push - (stt_pkg::FIFO_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      fifo_r[wp_r] <= ent0;
    end
    if (push1) begin
      fifo_r[wp_r + 1'b1] <= ent1;
    end
  end

  assign in_ch.ready = (cnt_r <= (stt_pkg::FIFO_AW + 1)'(stt_pkg::FIFO_DEPTH - 2));
  assign out_ch.valid = (cnt_r != '0);
  assign out_ch.item_kind = fifo_r[rp_r].item.kind;
  assign out_ch.token_kind = fifo_r[rp_r].item.tok;
  assign out_ch.int_value = fifo_r[rp_r].item.value;
  assign out_ch.text_byte = fifo_r[rp_r].item.tbyte;
  assign out_ch.text_length = fifo_r[rp_r].item.tlen;
  assign out_ch.line_number = fifo_r[rp_r].line;
  assign out_ch.error_code = fifo_r[rp_r].item.err;
  assign out_ch.last_of_run = fifo_r[rp_r].last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (stt_pkg::FIFO_AW + 1)'(stt_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (ph_r == stt_pkg::PH_DONE || ph_r == stt_pkg::PH_ERROR)) |-> !push0)
    else $error("result produced after end of source or error");

  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (push0 && ent0.item.kind == stt_pkg::IK_ERROR) |=> ph_r == stt_pkg::PH_ERROR)
    else $error("error result did not enter the error phase");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line count reached zero");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> (!ent0.last && ent0.item.kind != stt_pkg::IK_ERROR))
    else $error("first of two results marked last or an error");

endmodule
